[src/aes_pkg.sv]
`default_nettype none

package aes_pkg;

    localparam int BYTE_W      = 8;
    localparam int BYTE_LIM_W  = 17;
    localparam int LINE_LIM_W  = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [BYTE_LIM_W-1:0] BYTE_LIMIT_RST = 17'd65536;
    localparam logic [LINE_LIM_W-1:0] LINE_LIMIT_RST = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 2'd1;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BEL    = 8'h07;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4,
        MODE_STOP    = 3'd5
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] clean_byte;
        logic              has_byte;
        logic              done_res;
        logic              clipped;
    } t_result;

    typedef struct packed {
        logic [BYTE_LIM_W-1:0] byte_limit;
        logic [LINE_LIM_W-1:0] line_limit;
    } t_limits;

endpackage

`default_nettype wire

[src/aes_cfg.sv]
`default_nettype none

module aes_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [aes_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [aes_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output aes_pkg::t_limits                   o_limits
);

    logic [aes_pkg::BYTE_LIM_W-1:0] r_byte_limit;
    logic [aes_pkg::LINE_LIM_W-1:0] r_line_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit <= aes_pkg::BYTE_LIMIT_RST;
            r_line_limit <= aes_pkg::LINE_LIMIT_RST;
        end else if (i_cfg_we) begin
            // unknown indexes fall through and are ignored
            if (i_cfg_idx == aes_pkg::CFG_BYTE_LIMIT) begin
                r_byte_limit <= i_cfg_data[aes_pkg::BYTE_LIM_W-1:0];
            end
            if (i_cfg_idx == aes_pkg::CFG_LINE_LIMIT) begin
                r_line_limit <= i_cfg_data[aes_pkg::LINE_LIM_W-1:0];
            end
        end
    end

    assign o_limits.byte_limit = r_byte_limit;
    assign o_limits.line_limit = r_line_limit;

endmodule

`default_nettype wire

[src/aes_scan.sv]
`default_nettype none

module aes_scan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [aes_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_last,
    input  wire aes_pkg::t_limits           i_limits,
    output logic                            o_gen,
    output aes_pkg::t_result                o_result
);

    aes_pkg::t_mode                 r_mode, n_mode;
    logic [aes_pkg::BYTE_LIM_W-1:0] r_bytes, n_bytes;
    logic [aes_pkg::LINE_LIM_W-1:0] r_nl, n_nl;
    logic                           r_clip, n_clip;

    logic                       has;
    logic [aes_pkg::BYTE_W-1:0] keep;
    logic [aes_pkg::LINE_LIM_W:0] nl_inc;

    assign nl_inc = {1'b0, r_nl} + {{aes_pkg::LINE_LIM_W{1'b0}}, 1'b1};

    always_comb begin
        n_mode  = r_mode;
        n_bytes = r_bytes;
        n_nl    = r_nl;
        n_clip  = r_clip;
        has     = 1'b0;
        keep    = aes_pkg::CH_NUL;
        if (r_mode != aes_pkg::MODE_STOP) begin
            priority if (i_byte == aes_pkg::CH_NUL) begin
                n_mode = aes_pkg::MODE_STOP;
            end else if (r_bytes >= i_limits.byte_limit) begin
                n_clip = 1'b1;
                n_mode = aes_pkg::MODE_STOP;
            end else begin
                n_bytes = r_bytes + 1'b1;
                unique case (r_mode)
                    aes_pkg::MODE_ESC: begin
                        priority if (i_byte == aes_pkg::CH_LBRACK) n_mode = aes_pkg::MODE_CSI;
                        else if (i_byte == aes_pkg::CH_RBRACK) n_mode = aes_pkg::MODE_OSC;
                        else n_mode = aes_pkg::MODE_NORMAL;
                    end
                    aes_pkg::MODE_CSI: begin
                        if (i_byte >= aes_pkg::CH_AT && i_byte <= aes_pkg::CH_TILDE) begin
                            n_mode = aes_pkg::MODE_NORMAL;
                        end
                    end
                    aes_pkg::MODE_OSC: begin
                        priority if (i_byte == aes_pkg::CH_BEL) n_mode = aes_pkg::MODE_NORMAL;
                        else if (i_byte == aes_pkg::CH_ESC) n_mode = aes_pkg::MODE_OSC_ESC;
                        else n_mode = aes_pkg::MODE_OSC;
                    end
                    aes_pkg::MODE_OSC_ESC: begin
                        priority if (i_byte == aes_pkg::CH_BSLASH || i_byte == aes_pkg::CH_BEL) begin
                            n_mode = aes_pkg::MODE_NORMAL;
                        end else if (i_byte != aes_pkg::CH_ESC) begin
                            n_mode = aes_pkg::MODE_OSC;
                        end else begin
                            n_mode = aes_pkg::MODE_OSC_ESC;
                        end
                    end
                    default: begin
                        // plain text
                        priority if (i_byte == aes_pkg::CH_ESC) begin
                            n_mode = aes_pkg::MODE_ESC;
                        end else if (i_byte == aes_pkg::CH_TAB) begin
                            has  = 1'b1;
                            keep = i_byte;
                        end else if (i_byte == aes_pkg::CH_NL) begin
                            if (nl_inc >= {1'b0, i_limits.line_limit}) begin
                                n_clip = 1'b1;
                                n_mode = aes_pkg::MODE_STOP;
                            end else begin
                                n_nl = nl_inc[aes_pkg::LINE_LIM_W-1:0];
                                has  = 1'b1;
                                keep = i_byte;
                            end
                        end else if (i_byte < aes_pkg::CH_SPACE) begin
                            has = 1'b0;
                        end else begin
                            has  = 1'b1;
                            keep = (i_byte == aes_pkg::CH_DEL) ? aes_pkg::CH_SPACE : i_byte;
                        end
                    end
                endcase
            end
        end

        o_gen               = has | i_last;
        o_result.clean_byte = keep;
        o_result.has_byte   = has;
        o_result.done_res   = i_last;
        o_result.clipped    = n_clip;

        // string ends: back to a clean slate
        if (i_last) begin
            n_mode  = aes_pkg::MODE_NORMAL;
            n_bytes = '0;
            n_nl    = '0;
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= aes_pkg::MODE_NORMAL;
            r_bytes <= '0;
            r_nl    <= '0;
            r_clip  <= 1'b0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_bytes <= n_bytes;
            r_nl    <= n_nl;
            r_clip  <= n_clip;
        end
    end

    a_kept_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_result.has_byte |-> (o_result.clean_byte >= aes_pkg::CH_SPACE
            || o_result.clean_byte == aes_pkg::CH_TAB || o_result.clean_byte == aes_pkg::CH_NL))
        else $error("kept byte is a dropped control code");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_last |=> r_mode == aes_pkg::MODE_NORMAL && r_bytes == '0
            && r_nl == '0 && !r_clip)
        else $error("string state not cleared after last byte");

    a_clip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip && !(i_advance && i_last) |=> r_clip)
        else $error("clip flag dropped inside a string");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == aes_pkg::MODE_STOP && !(i_advance && i_last) |=>
            r_mode == aes_pkg::MODE_STOP && $stable(r_bytes))
        else $error("stopped string resumed scanning");

endmodule

`default_nettype wire

[src/aes_out.sv]
`default_nettype none

module aes_out (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire aes_pkg::t_result           i_result,
    input  wire logic                       i_out_stall,
    output logic                            o_ready,
    output logic                            o_out_valid,
    output logic [aes_pkg::BYTE_W-1:0]      o_clean_byte,
    output logic                            o_has_byte,
    output logic                            o_done_res,
    output logic                            o_clipped
);

    logic             r_valid;
    aes_pkg::t_result r_result;

    // room when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_clean_byte = r_result.clean_byte;
    assign o_has_byte   = r_result.has_byte;
    assign o_done_res   = r_result.done_res;
    assign o_clipped    = r_result.clipped;

endmodule

`default_nettype wire

[src/ansi_escape_stripper.sv]
// channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_raw_byte, i_end_of_string
// out     | o_out_valid| i_out_stall | o_clean_byte, o_has_byte, o_done_res, o_clipped
// cfg     | i_cfg_we   | -           | i_cfg_idx, i_cfg_data
//
// One byte per cycle unless stalled: input register, one pass through the mode machine,
// result register. Bytes that yield a result load the result register as they leave the
// input register; bytes that yield no result only update the scan state.
// Reset (synchronous, active low) empties both registers and restores the default limits.
// A stalled result holds the pipe only when the byte in the input register yields a result.
`default_nettype none

module ansi_escape_stripper (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [aes_pkg::BYTE_W-1:0]     i_raw_byte,
    input  wire logic                           i_end_of_string,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [aes_pkg::BYTE_W-1:0]          o_clean_byte,
    output logic                                o_has_byte,
    output logic                                o_done_res,
    output logic                                o_clipped,
    input  wire logic                           i_cfg_we,
    input  wire logic [aes_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [aes_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                       r_in_valid;
    logic [aes_pkg::BYTE_W-1:0] r_byte;
    logic                       r_last;

    aes_pkg::t_limits limits;
    aes_pkg::t_result result;
    logic             gen;
    logic             out_ready;
    logic             advance;

    // byte moves on unless it has a result and the result register is full and stalled
    assign advance    = r_in_valid && (!gen || out_ready);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_raw_byte;
            r_last <= i_end_of_string;
        end
    end

    aes_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_limits   (limits)
    );

    aes_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_byte),
        .i_last    (r_last),
        .i_limits  (limits),
        .o_gen     (gen),
        .o_result  (result)
    );

    aes_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && gen),
        .i_result     (result),
        .i_out_stall  (i_out_stall),
        .o_ready      (out_ready),
        .o_out_valid  (o_out_valid),
        .o_clean_byte (o_clean_byte),
        .o_has_byte   (o_has_byte),
        .o_done_res   (o_done_res),
        .o_clipped    (o_clipped)
    );

    a_held_byte_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_byte) && $stable(r_last))
        else $error("waiting input byte lost");

    a_no_result_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !gen |-> advance)
        else $error("byte without result stalled the pipe");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && gen |=> o_out_valid)
        else $error("result not captured");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

    typedef logic [aes_pkg::BYTE_W-1:0]     t_byte;
    typedef logic [aes_pkg::BYTE_LIM_W-1:0] t_blim;
    typedef logic [aes_pkg::LINE_LIM_W-1:0] t_llim;
    typedef logic [aes_pkg::CFG_DATA_W-1:0] t_cdata;

    // index 3 has no register behind it; writes there must be ignored
    localparam logic [aes_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic             cfg;
        t_blim            byte_lim;
        t_llim            line_lim;
        t_byte            raw;
        logic             eos;
        logic             fix;
        aes_pkg::t_result res;
    } t_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    t_byte                             i_raw_byte;
    logic                              i_end_of_string;
    logic                              o_out_valid;
    logic                              i_out_stall;
    t_byte                             o_clean_byte;
    logic                              o_has_byte;
    logic                              o_done_res;
    logic                              o_clipped;
    logic                              i_cfg_we;
    logic [aes_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    t_cdata                            i_cfg_data;

    // scan state mirrored from the block
    aes_pkg::t_limits      lim;
    aes_pkg::t_mode        scan;
    t_blim                 seen;
    t_llim                 lines;
    logic                  clip;

    aes_pkg::t_result      pending_clean[$];
    t_row                  drill[$];
    t_byte                 text_q[$];

    // typed expectation travels with the payload so the monitor sees it at the transfer
    logic                  row_fix;
    aes_pkg::t_result      row_res;

    int unsigned           err_cnt;
    int unsigned           tx_pct;
    int unsigned           rx_pct;
    int unsigned           phase_items;
    bit                    squeeze_req;
    bit                    pred_emit;
    aes_pkg::t_result      pred_res;
    aes_pkg::t_result      want;

    ansi_escape_stripper i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_byte      (i_raw_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_clean_byte    (o_clean_byte),
        .o_has_byte      (o_has_byte),
        .o_done_res      (o_done_res),
        .o_clipped       (o_clipped),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic int unsigned idle_len(input int unsigned pct);
        if (pct == 0 || $urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(30, 10);
        return $urandom_range(3, 1);
    endfunction

    task automatic scrub_byte(input t_byte b, input logic eos,
                              output bit emit, output aes_pkg::t_result r);
        t_byte keep;
        bit    has;
        has  = 1'b0;
        keep = '0;
        if (scan != aes_pkg::MODE_STOP) begin
            if (b == aes_pkg::CH_NUL) begin
                scan = aes_pkg::MODE_STOP;
            end else if (seen >= lim.byte_limit) begin
                clip = 1'b1;
                scan = aes_pkg::MODE_STOP;
            end else begin
                seen = seen + 1'b1;
                case (scan)
                    aes_pkg::MODE_ESC: begin
                        if (b == aes_pkg::CH_LBRACK) scan = aes_pkg::MODE_CSI;
                        else if (b == aes_pkg::CH_RBRACK) scan = aes_pkg::MODE_OSC;
                        else scan = aes_pkg::MODE_NORMAL;
                    end
                    aes_pkg::MODE_CSI: begin
                        if (b >= aes_pkg::CH_AT && b <= aes_pkg::CH_TILDE) begin
                            scan = aes_pkg::MODE_NORMAL;
                        end
                    end
                    aes_pkg::MODE_OSC: begin
                        if (b == aes_pkg::CH_BEL) scan = aes_pkg::MODE_NORMAL;
                        else if (b == aes_pkg::CH_ESC) scan = aes_pkg::MODE_OSC_ESC;
                    end
                    aes_pkg::MODE_OSC_ESC: begin
                        if (b == aes_pkg::CH_BSLASH || b == aes_pkg::CH_BEL) begin
                            scan = aes_pkg::MODE_NORMAL;
                        end else if (b != aes_pkg::CH_ESC) begin
                            scan = aes_pkg::MODE_OSC;
                        end
                    end
                    default: begin
                        if (b == aes_pkg::CH_ESC) begin
                            scan = aes_pkg::MODE_ESC;
                        end else if (b == aes_pkg::CH_TAB) begin
                            has  = 1'b1;
                            keep = b;
                        end else if (b == aes_pkg::CH_NL) begin
                            // newline that would open one line too many
                            if ({1'b0, lines} + 10'd1 >= {1'b0, lim.line_limit}) begin
                                clip = 1'b1;
                                scan = aes_pkg::MODE_STOP;
                            end else begin
                                lines = lines + 1'b1;
                                has   = 1'b1;
                                keep  = b;
                            end
                        end else if (b >= aes_pkg::CH_SPACE) begin
                            has  = 1'b1;
                            keep = (b == aes_pkg::CH_DEL) ? aes_pkg::CH_SPACE : b;
                        end
                    end
                endcase
            end
        end
        emit         = has || eos;
        r.clean_byte = keep;
        r.has_byte   = has;
        r.done_res   = eos;
        r.clipped    = clip;
        if (eos) begin
            scan  = aes_pkg::MODE_NORMAL;
            seen  = '0;
            lines = '0;
            clip  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                scrub_byte(i_raw_byte, i_end_of_string, pred_emit, pred_res);
                if (row_fix) pending_clean.push_back(row_res);
                else if (pred_emit) pending_clean.push_back(pred_res);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_clean.size() == 0) begin
                    $error("result with no transfer pending: clean_byte %0h", o_clean_byte);
                    err_cnt++;
                end else begin
                    want = pending_clean.pop_front();
                    if (o_clean_byte !== want.clean_byte) begin
                        $error("clean_byte: expected %0h, got %0h", want.clean_byte, o_clean_byte);
                        err_cnt++;
                    end
                    if (o_has_byte !== want.has_byte) begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte, o_has_byte);
                        err_cnt++;
                    end
                    if (o_done_res !== want.done_res) begin
                        $error("done_res: expected %0b, got %0b", want.done_res, o_done_res);
                        err_cnt++;
                    end
                    if (o_clipped !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b", want.clipped, o_clipped);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold = 59;
                i_out_stall <= 1'b1;
            end else begin
                hold = idle_len(rx_pct);
                if (hold != 0) begin
                    hold--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic push_byte(input t_byte b, input logic eos,
                             input logic fix, input aes_pkg::t_result res);
        int unsigned gap;
        gap = idle_len(tx_pct);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_raw_byte      <= b;
        i_end_of_string <= eos;
        row_fix         <= fix;
        row_res         <= res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // a byte that yields no result can still be in the pipe once the queue is empty
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_clean.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_limits(input t_blim bl, input t_llim ll);
        drain_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= aes_pkg::CFG_BYTE_LIMIT;
        i_cfg_data <= bl;
        @(posedge i_clk);
        i_cfg_idx  <= aes_pkg::CFG_LINE_LIMIT;
        i_cfg_data <= t_cdata'(ll);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= t_cdata'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lim.byte_limit = bl;
        lim.line_limit = ll;
    endtask

    function automatic void row_item(input t_byte b, input logic eos);
        t_row r;
        r     = '0;
        r.raw = b;
        r.eos = eos;
        drill.push_back(r);
    endfunction

    function automatic void row_pin(input t_byte b, input logic eos,
                                    input t_byte cb, input logic has,
                                    input logic done, input logic clp);
        t_row r;
        r                = '0;
        r.raw            = b;
        r.eos            = eos;
        r.fix            = 1'b1;
        r.res.clean_byte = cb;
        r.res.has_byte   = has;
        r.res.done_res   = done;
        r.res.clipped    = clp;
        drill.push_back(r);
    endfunction

    function automatic void row_cfg(input t_blim bl, input t_llim ll);
        t_row r;
        r          = '0;
        r.cfg      = 1'b1;
        r.byte_lim = bl;
        r.line_lim = ll;
        drill.push_back(r);
    endfunction

    function automatic void add_token();
        int unsigned k;
        int unsigned n;
        k = $urandom_range(99);
        if (k < 35) begin
            n = $urandom_range(4, 1);
            repeat (n) text_q.push_back(t_byte'($urandom_range(8'h7E, 8'h20)));
        end else if (k < 45) begin
            text_q.push_back(aes_pkg::CH_NL);
        end else if (k < 48) begin
            text_q.push_back(aes_pkg::CH_TAB);
        end else if (k < 51) begin
            text_q.push_back(aes_pkg::CH_DEL);
        end else if (k < 56) begin
            text_q.push_back(t_byte'($urandom_range(8'hFF, 8'h80)));
        end else if (k < 61) begin
            text_q.push_back(t_byte'($urandom_range(8'h1F, 8'h01)));
        end else if (k < 74) begin
            // CSI: parameter bytes then a final byte
            text_q.push_back(aes_pkg::CH_ESC);
            text_q.push_back(aes_pkg::CH_LBRACK);
            n = $urandom_range(3, 0);
            repeat (n) text_q.push_back(t_byte'($urandom_range(8'h3F, 8'h30)));
            text_q.push_back(t_byte'($urandom_range(aes_pkg::CH_TILDE, aes_pkg::CH_AT)));
        end else if (k < 84) begin
            text_q.push_back(aes_pkg::CH_ESC);
            text_q.push_back(aes_pkg::CH_RBRACK);
            n = $urandom_range(4, 0);
            repeat (n) text_q.push_back(t_byte'($urandom_range(8'h7E, 8'h20)));
            case ($urandom_range(3))
                0: text_q.push_back(aes_pkg::CH_BEL);
                1: begin
                    text_q.push_back(aes_pkg::CH_ESC);
                    text_q.push_back(aes_pkg::CH_BSLASH);
                end
                2: begin
                    text_q.push_back(aes_pkg::CH_ESC);
                    text_q.push_back(aes_pkg::CH_ESC);
                    text_q.push_back(aes_pkg::CH_BSLASH);
                end
                default: begin
                    // escape plus a printable byte inside OSC, then BEL (a backslash there ends the OSC)
                    text_q.push_back(aes_pkg::CH_ESC);
                    text_q.push_back(t_byte'($urandom_range(8'h7E, 8'h20)));
                    text_q.push_back(aes_pkg::CH_BEL);
                end
            endcase
        end else if (k < 89) begin
            text_q.push_back(aes_pkg::CH_ESC);
            text_q.push_back(t_byte'($urandom_range(8'hFF, 8'h00)));
        end else if (k < 92) begin
            text_q.push_back(aes_pkg::CH_NUL);
        end else begin
            text_q.push_back(t_byte'($urandom_range(8'hFF, 8'h00)));
        end
    endfunction

    task automatic send_string();
        int unsigned target;
        if ($urandom_range(9) == 0) target = $urandom_range(40, 13);
        else target = $urandom_range(12, 1);
        text_q.delete();
        while (text_q.size() < target) add_token();
        for (int i = 0; i < text_q.size(); i++)
            push_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
        phase_items += text_q.size();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_raw_byte      <= '0;
        i_end_of_string <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        row_fix         <= 1'b0;
        row_res         <= '0;
        err_cnt     = 0;
        squeeze_req = 1'b0;
        tx_pct      = 30;
        rx_pct      = 30;
        lim.byte_limit = aes_pkg::BYTE_LIMIT_RST;
        lim.line_limit = aes_pkg::LINE_LIMIT_RST;
        scan  = aes_pkg::MODE_NORMAL;
        seen  = '0;
        lines = '0;
        clip  = 1'b0;

        // limits at their reset values: plain text, controls, DEL, sequences, NUL stop
        row_pin(8'h41, 1'b0, 8'h41, 1'b1, 1'b0, 1'b0);
        row_pin(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0);
        row_pin(aes_pkg::CH_DEL, 1'b0, aes_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0);
        row_item(8'h01, 1'b0);
        row_pin(aes_pkg::CH_TAB, 1'b0, aes_pkg::CH_TAB, 1'b1, 1'b0, 1'b0);
        row_item(aes_pkg::CH_NL, 1'b0);
        row_item(aes_pkg::CH_ESC, 1'b0);
        row_item(aes_pkg::CH_LBRACK, 1'b0);
        row_item(aes_pkg::CH_AT, 1'b0);
        row_item(aes_pkg::CH_ESC, 1'b0);
        row_item(aes_pkg::CH_RBRACK, 1'b0);
        row_item(aes_pkg::CH_ESC, 1'b0);
        row_item(aes_pkg::CH_ESC, 1'b0);
        row_item(aes_pkg::CH_BSLASH, 1'b0);
        row_item(aes_pkg::CH_ESC, 1'b0);
        row_item(8'h63, 1'b0);
        row_item(aes_pkg::CH_NUL, 1'b0);
        row_pin(aes_pkg::CH_TILDE, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
        // byte limit hit on the third byte, line limit hit on the first newline
        row_cfg(17'd2, 9'd1);
        row_pin(8'h61, 1'b0, 8'h61, 1'b1, 1'b0, 1'b0);
        row_pin(8'h62, 1'b0, 8'h62, 1'b1, 1'b0, 1'b0);
        row_pin(8'h63, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        row_pin(aes_pkg::CH_NL, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        // zero limits clip the first byte
        row_cfg(17'd0, 9'd0);
        row_pin(8'h71, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        // sequence left open at the end of the string
        row_cfg(aes_pkg::BYTE_LIMIT_RST, aes_pkg::LINE_LIMIT_RST);
        row_item(aes_pkg::CH_ESC, 1'b0);
        row_item(aes_pkg::CH_LBRACK, 1'b0);
        row_pin(8'h31, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (drill[i]) begin
            if (drill[i].cfg) set_limits(drill[i].byte_lim, drill[i].line_lim);
            else push_byte(drill[i].raw, drill[i].eos, drill[i].fix, drill[i].res);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_limits(aes_pkg::BYTE_LIMIT_RST, aes_pkg::LINE_LIMIT_RST);
                1: set_limits(17'd1, 9'd1);
                2: set_limits('1, '1);
                3, 4: set_limits(t_blim'($urandom_range(40, 3)),
                                 t_llim'($urandom_range(6, 1)));
                default: set_limits(t_blim'($urandom_range(65536, 1)),
                                    t_llim'($urandom_range(256, 1)));
            endcase
            if (p == 0) begin
                // back-to-back traffic into a receiver that holds off for a while
                tx_pct      = 0;
                rx_pct      = 0;
                squeeze_req = 1'b1;
            end else begin
                tx_pct = ($urandom_range(2) == 0) ? 10 : $urandom_range(60, 20);
                rx_pct = ($urandom_range(2) == 0) ? 10 : $urandom_range(60, 20);
            end
            phase_items = 0;
            while (phase_items < 70) send_string();
        end

        drain_pipe();
        if (err_cnt == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

endmodule
